FILE: sv/gdd_pkg.sv
// Shared types, constants and table functions for the Gregorian date difference block.
// Used by gregorian_date_difference; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gdd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned COUNT_W = 22;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;

    // Quotient unit operand and result widths.
    localparam int unsigned DIV_IN_W = 13;
    localparam int unsigned DIV_Q_W  = 9;

    // Reciprocal of 25 scaled by 2^17, rounded up; exact for inputs below 43690.
    localparam int unsigned RECIP25_SHIFT = 17;
    localparam logic [25:0] RECIP25       = 26'd5243;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_ADD4   = 9'b000000100,
        S_SUB100 = 9'b000001000,
        S_ADD400 = 9'b000010000,
        S_CHK100 = 9'b000100000,
        S_CHK400 = 9'b001000000,
        S_MON    = 9'b010000000,
        S_DIFF   = 9'b100000000
    } t_state;

    function automatic logic [DIV_Q_W-1:0] div25(input logic [DIV_IN_W-1:0] x);
        logic [25:0] prod;
        prod = 26'(x) * RECIP25;
        return prod[RECIP25_SHIFT +: DIV_Q_W];
    endfunction

    // Days in the year before the first of the month; 0 for a month code out of range.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        unique case (m)
            4'd2:                                r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:             r = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
            4'd12:                               r = 5'd31;
            default:                             r = 5'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/gregorian_date_difference.sv
// Top level of the Gregorian date difference block: sequencer around one shared
// adder/subtractor and one divide-by-25 reciprocal unit. Depends on gdd_pkg.
//
// Usage: drive both dates on the i_year_*, i_month_*, i_day_* ports and raise start.
// The request is taken at a rising edge where start is high and busy is low; the
// dates are captured then and need not stay. busy stays high while the request
// is worked on. The result appears on o_day_count and o_bad_date for exactly one
// cycle with o_valid high; the receiver cannot stall, so it must take it then.
// o_valid goes high in the same cycle in which busy drops; the block takes no new
// request before it is through with the last one. Each date takes seven steps:
// 365*year and the three leap-year corrections through the shared adder, two
// divisibility checks through the divide-by-25 unit, and the month and day
// offset through the adder; then one step forms the absolute difference. A date
// with a year above 9999, a month outside 1..12, or a day outside its month
// gives o_bad_date high and a count of 0. Synchronous reset (i_rst_n low)
// returns the sequencer to idle and drops o_valid; a request in flight is lost.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_difference (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [gdd_pkg::YEAR_W-1:0]          i_year_a,
    input  wire  [gdd_pkg::MONTH_W-1:0]         i_month_a,
    input  wire  [gdd_pkg::DAY_W-1:0]           i_day_a,
    input  wire  [gdd_pkg::YEAR_W-1:0]          i_year_b,
    input  wire  [gdd_pkg::MONTH_W-1:0]         i_month_b,
    input  wire  [gdd_pkg::DAY_W-1:0]           i_day_b,
    output logic                                o_valid,
    output logic [gdd_pkg::COUNT_W-1:0]         o_day_count,
    output logic                                o_bad_date
);
    import gdd_pkg::*;

    t_state                 r_state, n_state;
    logic                   r_sel, n_sel;
    logic [YEAR_W-1:0]      r_year_a, r_year_b;
    logic [MONTH_W-1:0]     r_month_a, r_month_b;
    logic [DAY_W-1:0]       r_day_a, r_day_b;
    logic [COUNT_W-1:0]     r_acc, n_acc;
    logic [COUNT_W-1:0]     r_sa, n_sa;
    logic                   r_bad, n_bad;
    logic                   r_z100, n_z100;
    logic                   r_z400, n_z400;
    logic                   r_valid, n_valid;
    logic [COUNT_W-1:0]     r_count, n_count;
    logic                   r_bad_out, n_bad_out;

    // Current date
    logic [YEAR_W-1:0]      cur_y;
    logic [MONTH_W-1:0]     cur_m;
    logic [DAY_W-1:0]       cur_d;
    logic                   leap;
    logic                   date_ok;

    // Shared units
    logic [COUNT_W-1:0]     u_a, u_b, u_sum;
    logic                   u_sub;
    logic [DIV_IN_W-1:0]    dv_in;
    logic [DIV_Q_W-1:0]     dv_q;
    logic [DIV_IN_W-1:0]    dv_back;
    logic                   dv_exact;

    logic [YEAR_W:0]        y_p3, y_p99, y_p399;
    logic [COUNT_W-1:0]     mon_add;
    logic                   take;

    assign take = start && !busy;

    always_comb begin
        cur_y = r_sel ? r_year_b  : r_year_a;
        cur_m = r_sel ? r_month_b : r_month_a;
        cur_d = r_sel ? r_day_b   : r_day_a;
    end

    assign y_p3   = {1'b0, cur_y} + (YEAR_W+1)'(3);
    assign y_p99  = {1'b0, cur_y} + (YEAR_W+1)'(99);
    assign y_p399 = {1'b0, cur_y} + (YEAR_W+1)'(399);

    assign leap = (cur_y[1:0] == 2'b00) && (!r_z100 || r_z400);

    assign date_ok = (cur_y <= YEAR_MAX)
                  && (cur_m != '0) && (cur_m <= MONTH_LAST)
                  && (cur_d != '0) && (cur_d <= month_len(cur_m, leap));

    assign mon_add = COUNT_W'(days_before(cur_m))
                   + COUNT_W'((cur_m > MONTH_FEB) && leap)
                   + COUNT_W'(cur_d) - COUNT_W'(1);

    // Divide-by-25 operand: /100 and /400 are a shift followed by /25.
    always_comb begin
        unique case (r_state)
            S_SUB100: dv_in = DIV_IN_W'(y_p99 >> 2);
            S_ADD400: dv_in = DIV_IN_W'(y_p399 >> 4);
            S_CHK100: dv_in = DIV_IN_W'(cur_y >> 2);
            S_CHK400: dv_in = DIV_IN_W'(cur_y >> 4);
            default:  dv_in = '0;
        endcase
    end

    assign dv_q     = div25(dv_in);
    assign dv_back  = (DIV_IN_W'(dv_q) << 4) + (DIV_IN_W'(dv_q) << 3) + DIV_IN_W'(dv_q);
    assign dv_exact = (dv_back == dv_in);

    // Adder operand selection
    always_comb begin
        u_a   = r_acc;
        u_b   = '0;
        u_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                u_a = '0;
                u_b = COUNT_W'(cur_y) * COUNT_W'(365);
            end
            S_ADD4:   u_b = COUNT_W'(y_p3 >> 2);
            S_SUB100: begin
                u_b   = COUNT_W'(dv_q);
                u_sub = 1'b1;
            end
            S_ADD400: u_b = COUNT_W'(dv_q);
            S_MON:    u_b = mon_add;
            S_DIFF: begin
                u_sub = 1'b1;
                if (r_sa >= r_acc) begin
                    u_a = r_sa;
                    u_b = r_acc;
                end else begin
                    u_a = r_acc;
                    u_b = r_sa;
                end
            end
            default: ;
        endcase
    end

    assign u_sum = u_sub ? (u_a - u_b) : (u_a + u_b);

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_acc     = r_acc;
        n_sa      = r_sa;
        n_bad     = r_bad;
        n_z100    = r_z100;
        n_z400    = r_z400;
        n_valid   = 1'b0;
        n_count   = r_count;
        n_bad_out = r_bad_out;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_state = S_MUL;
                    n_sel   = 1'b0;
                    n_bad   = 1'b0;
                end
            end
            S_MUL: begin
                n_acc   = u_sum;
                n_state = S_ADD4;
            end
            S_ADD4: begin
                n_acc   = u_sum;
                n_state = S_SUB100;
            end
            S_SUB100: begin
                n_acc   = u_sum;
                n_state = S_ADD400;
            end
            S_ADD400: begin
                n_acc   = u_sum;
                n_state = S_CHK100;
            end
            S_CHK100: begin
                n_z100  = (cur_y[1:0] == 2'b00) && dv_exact;
                n_state = S_CHK400;
            end
            S_CHK400: begin
                n_z400  = (cur_y[3:0] == 4'b0000) && dv_exact;
                n_state = S_MON;
            end
            S_MON: begin
                n_acc = u_sum;
                n_bad = r_bad || !date_ok;
                if (!r_sel) begin
                    n_sa    = u_sum;
                    n_sel   = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_count   = r_bad ? '0 : u_sum;
                n_bad_out = r_bad;
                n_valid   = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Payload and working registers; no reset needed.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_year_a  <= i_year_a;
            r_month_a <= i_month_a;
            r_day_a   <= i_day_a;
            r_year_b  <= i_year_b;
            r_month_b <= i_month_b;
            r_day_b   <= i_day_b;
        end
        r_sel     <= n_sel;
        r_acc     <= n_acc;
        r_sa      <= n_sa;
        r_bad     <= n_bad;
        r_z100    <= n_z100;
        r_z400    <= n_z400;
        r_count   <= n_count;
        r_bad_out <= n_bad_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_day_count = r_count;
    assign o_bad_date  = r_bad_out;

endmodule
`default_nettype wire
